>>> rtl/rsaf_pkg.sv
// Shared constants, codes and helpers for the spike-rejecting average filter.
// No dependencies; the top level imports this package.
`timescale 1ns / 1ps

package rsaf_pkg;

	// Field widths
	localparam int BYTE_W      = 8;
	localparam int VAL_W       = 12;
	localparam int STATUS_W    = 2;
	localparam int CFG_ADDR_W  = 2;

	// Stream payload widths
	localparam int IN_DATA_W   = 5 * BYTE_W;
	localparam int IN_USER_W   = 1;
	localparam int OUT_DATA_W  = 2 * VAL_W;
	localparam int OUT_USER_W  = STATUS_W + 1;

	// Default averaging window
	localparam int AVG_DEPTH_DEF = 8;

	// Register reset values, in tenths
	localparam logic [VAL_W-1:0] TEMP_LIMIT_RST = VAL_W'(50);
	localparam logic [VAL_W-1:0] HUM_LIMIT_RST  = VAL_W'(100);

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_TEMP_LIMIT = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_HUM_LIMIT  = CFG_ADDR_W'(1);

	// Request kind on the input tuser
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_RESET = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED  = 2'd0,
		ST_CHECK_ERR = 2'd1,
		ST_SPIKE     = 2'd2,
		ST_RESET     = 2'd3
	} status_t;

	// Whole byte times ten plus tenths byte; at most 2805, fits in VAL_W
	function automatic logic [VAL_W-1:0] to_tenths(input logic [BYTE_W-1:0] whole,
		input logic [BYTE_W-1:0] tenths);
		logic [VAL_W-1:0] w;
		w = VAL_W'(whole);
		return (w << 3) + (w << 1) + VAL_W'(tenths);
	endfunction

	// Absolute difference of two readings
	function automatic logic [VAL_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

>>> rtl/rsaf_hist.sv
// History ring storage for the average filter: one write and one registered read port.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module rsaf_hist #(
	parameter int DEPTH  = 8,
	parameter int DATA_W = 24,
	parameter int ADDR_W = 3
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write one entry per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/rsaf_div.sv
// Restoring bit-serial divider, one quotient bit per cycle, shared by both averages.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module rsaf_div #(
	parameter int DVD_W = 16,
	parameter int DVS_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

>>> rtl/reading_check_spike_average_filter_top.sv
// Top level of the spike-rejecting moving-average filter: sequencer, registers, stream ports.
// Depends on rsaf_pkg, rsaf_hist and rsaf_div.
`timescale 1ns / 1ps

// Each request is a five-byte humidity/temperature frame (tuser = 0) or a filter
// history reset (tuser = 1), and each gives exactly one result. A reset request or
// a frame that fails the checksum or spike test goes from the check state straight
// to the finish state. An accepted frame is written into the history ring, the ring
// is read back one entry a cycle to form both sums, and the shared serial divider
// then forms the temperature and humidity means one bit a cycle from SUM_W-bit sums
// (SUM_W = 12 + clog2(AVG_DEPTH + 1)). In every case the finish state waits until
// the output register is free, loads it and returns to idle. The input is not ready
// while a request is in work; a finished result waits in the output register, and
// the next request is taken meanwhile. Limits may be written at any time the block
// is idle; cfg_ready is always high. The history needs no clearing pass after reset.

module reading_check_spike_average_filter_top #(
	parameter int AVG_DEPTH = rsaf_pkg::AVG_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input request
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [7:0] hum_whole, [15:8] hum_tenths, [23:16] temp_whole, [31:24] temp_tenths,
	// [39:32] check_byte
	input  logic [rsaf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] op
	input  logic [rsaf_pkg::IN_USER_W-1:0]  s_axis_tuser,
	// Result
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [11:0] avg_temp, [23:12] avg_hum
	output logic [rsaf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [1:0] status, [2] output_valid
	output logic [rsaf_pkg::OUT_USER_W-1:0] m_axis_tuser,
	// Configuration write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsaf_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [rsaf_pkg::VAL_W-1:0]      cfg_data
);

	import rsaf_pkg::*;

	localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int CNT_W = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W = VAL_W + CNT_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_SUM    = 7'b0000100,
		S_DIV_T  = 7'b0001000,
		S_DIV_H  = 7'b0010000,
		S_FINISH = 7'b0100000,
		S_SPARE  = 7'b1000000
	} state_t;

	state_t              state_q;

	// Latched request
	logic                op_q;
	logic [BYTE_W-1:0]   hw_q, ht_q, tw_q, tt_q, ck_q;

	// Filter state
	logic [VAL_W-1:0]    temp_limit_q, hum_limit_q;
	logic [IDX_W-1:0]    slot_q;
	logic [CNT_W-1:0]    fill_q;
	logic [VAL_W-1:0]    last_temp_q, last_hum_q;
	logic                seen_first_q;
	logic [VAL_W-1:0]    held_temp_q, held_hum_q;
	logic                held_valid_q;
	status_t             status_q;

	// Ring walk
	logic [CNT_W-1:0]    iss_q;
	logic                rd_pend_q;
	logic [SUM_W-1:0]    sum_temp_q, sum_hum_q;

	// Output register
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	// Combinational helpers
	logic [BYTE_W-1:0]   cksum;
	logic [VAL_W-1:0]    temp_val, hum_val;
	logic                spike;
	logic                issue;
	logic                walk_done;
	logic                out_free;
	logic [2*VAL_W-1:0]  rd_data;
	logic                div_start;
	logic [SUM_W-1:0]    div_dividend;
	logic [SUM_W-1:0]    div_quotient;
	logic                div_done;
	logic                hist_wr;

	// Frame checks on the latched request
	always_comb begin
		cksum    = hw_q + ht_q + tw_q + tt_q;
		temp_val = to_tenths(tw_q, tt_q);
		hum_val  = to_tenths(hw_q, ht_q);
		spike    = seen_first_q &&
			((abs_diff(temp_val, last_temp_q) > temp_limit_q) ||
			 (abs_diff(hum_val, last_hum_q) > hum_limit_q));
	end

	assign hist_wr   = (state_q == S_CHECK) && (op_q == OP_FRAME) && (cksum == ck_q) && !spike;
	assign issue     = (state_q == S_SUM) && (iss_q != fill_q);
	assign walk_done = (state_q == S_SUM) && (iss_q == fill_q) && !rd_pend_q;
	assign out_free  = !out_valid_q || m_axis_tready;

	// Divider starts on temperature after the walk, then on humidity
	assign div_start    = walk_done || ((state_q == S_DIV_T) && div_done);
	assign div_dividend = (state_q == S_SUM) ? sum_temp_q : sum_hum_q;

	rsaf_hist #(
		.DEPTH  (AVG_DEPTH),
		.DATA_W (2 * VAL_W),
		.ADDR_W (IDX_W)
	) u_hist (
		.clk     (clk),
		.wr_en   (hist_wr),
		.wr_addr (slot_q),
		.wr_data ({hum_val, temp_val}),
		.rd_en   (issue),
		.rd_addr (iss_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	rsaf_div #(
		.DVD_W (SUM_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (fill_q),
		.quotient (div_quotient),
		.done     (div_done)
	);

	// Limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_limit_q <= TEMP_LIMIT_RST;
			hum_limit_q  <= HUM_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_TEMP_LIMIT: temp_limit_q <= cfg_data;
				REG_HUM_LIMIT:  hum_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Capture the request
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q <= s_axis_tuser[0];
			hw_q <= s_axis_tdata[BYTE_W-1:0];
			ht_q <= s_axis_tdata[2*BYTE_W-1:BYTE_W];
			tw_q <= s_axis_tdata[3*BYTE_W-1:2*BYTE_W];
			tt_q <= s_axis_tdata[4*BYTE_W-1:3*BYTE_W];
			ck_q <= s_axis_tdata[5*BYTE_W-1:4*BYTE_W];
		end
	end

	// Accumulate the ring readback
	always_ff @(posedge clk) begin
		if (hist_wr) begin
			sum_temp_q <= '0;
			sum_hum_q  <= '0;
		end else if (rd_pend_q) begin
			sum_temp_q <= sum_temp_q + SUM_W'(rd_data[VAL_W-1:0]);
			sum_hum_q  <= sum_hum_q + SUM_W'(rd_data[2*VAL_W-1:VAL_W]);
		end
	end

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_q       <= '0;
			fill_q       <= '0;
			last_temp_q  <= '0;
			last_hum_q   <= '0;
			seen_first_q <= 1'b0;
			held_temp_q  <= '0;
			held_hum_q   <= '0;
			held_valid_q <= 1'b0;
			status_q     <= ST_ACCEPTED;
			iss_q        <= '0;
			rd_pend_q    <= 1'b0;
		end else begin
			rd_pend_q <= issue;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (op_q == OP_RESET) begin
						// Clear history; held values and last readings stay
						slot_q       <= '0;
						fill_q       <= '0;
						seen_first_q <= 1'b0;
						held_valid_q <= 1'b0;
						status_q     <= ST_RESET;
						state_q      <= S_FINISH;
					end else if (cksum != ck_q) begin
						status_q <= ST_CHECK_ERR;
						state_q  <= S_FINISH;
					end else if (spike) begin
						status_q <= ST_SPIKE;
						state_q  <= S_FINISH;
					end else begin
						// Take the reading and start the ring walk
						last_temp_q  <= temp_val;
						last_hum_q   <= hum_val;
						seen_first_q <= 1'b1;
						slot_q       <= (slot_q == IDX_W'(AVG_DEPTH - 1)) ? '0 : slot_q + 1'b1;
						if (fill_q != CNT_W'(AVG_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
						iss_q    <= '0;
						status_q <= ST_ACCEPTED;
						state_q  <= S_SUM;
					end
				end
				S_SUM: begin
					if (issue) begin
						iss_q <= iss_q + 1'b1;
					end
					if (walk_done) begin
						state_q <= S_DIV_T;
					end
				end
				S_DIV_T: begin
					if (div_done) begin
						held_temp_q <= div_quotient[VAL_W-1:0];
						state_q     <= S_DIV_H;
					end
				end
				S_DIV_H: begin
					if (div_done) begin
						held_hum_q   <= div_quotient[VAL_W-1:0];
						held_valid_q <= 1'b1;
						state_q      <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FINISH) && out_free) begin
			out_data_q <= {held_hum_q, held_temp_q};
			out_user_q <= {held_valid_q, status_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule
